[rtl/assert_macros.svh]
// assertion macros used by the video timing generator rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that must hold at every clock edge out of reset
`define VDTG_ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("vdtg: invariant violated");

// antecedent in one cycle implies consequent in the next
`define VDTG_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vdtg: sequence violated");

`endif

[rtl/vdtg_pkg.sv]
// package: types and constants of the video timing generator
`timescale 1ns / 1ps

package vdtg_pkg;

  localparam int unsigned ColWidth  = 4;
  localparam int unsigned LineWidth = 9;

  localparam logic [1:0] FUNC_TICK   = 2'd0;
  localparam logic [1:0] FUNC_INPUT  = 2'd1;
  localparam logic [1:0] FUNC_OUTPUT = 2'd2;

  localparam logic [1:0] CPU_STATE_DMA = 2'd2;

  localparam logic [ColWidth-1:0] COL_LAST      = 4'd13;
  localparam logic [ColWidth-1:0] DMA_COL_FIRST = 4'd3;
  localparam logic [ColWidth-1:0] DMA_COL_LAST  = 4'd11;

  localparam logic [LineWidth-1:0] LINE_EF1_ON_A = 9'd60;
  localparam logic [LineWidth-1:0] LINE_IRQ_ON   = 9'd62;
  localparam logic [LineWidth-1:0] LINE_FIELD_ON = 9'd64;
  localparam logic [LineWidth-1:0] LINE_EF1_ON_B = 9'd188;
  localparam logic [LineWidth-1:0] LINE_FIELD_END = 9'd192;
  localparam logic [LineWidth-1:0] LINE_LAST     = 9'd261;

  typedef struct packed {
    logic [1:0] func;
    logic [1:0] cpu_state;
    logic [7:0] data_bus;
  } item_t;

  typedef struct packed {
    logic                 flag_ef1;
    logic                 irq_out;
    logic                 dma_request;
    logic                 pixel_valid;
    logic [7:0]           pixels;
    logic [ColWidth-1:0]  column;
    logic [LineWidth-1:0] line;
    logic                 frame_start;
  } result_t;

endpackage

[rtl/vdtg_timing.sv]
// column and line counters, flag levels, display enable and pixel fetch
`timescale 1ns / 1ps
`include "assert_macros.svh"

module vdtg_timing (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  vdtg_pkg::item_t  item,
  output vdtg_pkg::result_t result
);

  logic [vdtg_pkg::ColWidth-1:0]  column_count;
  logic [vdtg_pkg::LineWidth-1:0] line_count;
  logic display_enable;
  logic enable_latch;
  logic ef1_level;
  logic irq_level;

  logic [vdtg_pkg::ColWidth-1:0]  column_count_next;
  logic [vdtg_pkg::LineWidth-1:0] line_count_next;
  logic display_enable_next;
  logic enable_latch_next;
  logic ef1_level_next;
  logic irq_level_next;
  logic wrap;
  logic tick;
  logic [7:0] pix;
  logic in_field;

  always_comb begin
    column_count_next   = column_count;
    line_count_next     = line_count;
    display_enable_next = display_enable;
    enable_latch_next   = enable_latch;
    ef1_level_next      = ef1_level;
    irq_level_next      = irq_level;
    wrap                = 1'b0;
    tick                = 1'b0;
    unique case (item.func)
      vdtg_pkg::FUNC_TICK: begin
        tick = 1'b1;
        if (column_count == vdtg_pkg::COL_LAST) begin
          column_count_next = '0;
          if (line_count == vdtg_pkg::LINE_LAST) begin
            line_count_next     = '0;
            display_enable_next = enable_latch;
            wrap                = 1'b1;
          end else begin
            line_count_next = line_count + 9'd1;
            priority if (line_count_next == vdtg_pkg::LINE_EF1_ON_A) begin
              ef1_level_next = 1'b1;
            end else if (line_count_next == vdtg_pkg::LINE_IRQ_ON) begin
              irq_level_next = 1'b1;
            end else if (line_count_next == vdtg_pkg::LINE_FIELD_ON) begin
              irq_level_next = 1'b0;
              ef1_level_next = 1'b0;
            end else if (line_count_next == vdtg_pkg::LINE_EF1_ON_B) begin
              ef1_level_next = 1'b1;
            end else if (line_count_next == vdtg_pkg::LINE_FIELD_END) begin
              ef1_level_next = 1'b0;
            end else begin
            end
          end
        end else begin
          column_count_next = column_count + 4'd1;
        end
      end
      vdtg_pkg::FUNC_INPUT:  enable_latch_next = 1'b1;
      vdtg_pkg::FUNC_OUTPUT: enable_latch_next = 1'b0;
      default: begin
      end
    endcase
  end

  assign in_field = (line_count_next >= vdtg_pkg::LINE_FIELD_ON)
                 && (line_count_next <  vdtg_pkg::LINE_FIELD_END);

  assign pix = (tick && in_field && item.cpu_state == vdtg_pkg::CPU_STATE_DMA)
             ? item.data_bus : 8'd0;

  always_comb begin
    result.flag_ef1    = ef1_level_next;
    result.irq_out     = irq_level_next;
    result.dma_request = display_enable_next && in_field
                      && (column_count_next >= vdtg_pkg::DMA_COL_FIRST)
                      && (column_count_next <= vdtg_pkg::DMA_COL_LAST);
    result.pixel_valid = tick;
    result.pixels      = pix;
    result.column      = column_count_next;
    result.line        = line_count_next;
    result.frame_start = wrap;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count   <= '0;
      line_count     <= '0;
      display_enable <= 1'b0;
      enable_latch   <= 1'b0;
      ef1_level      <= 1'b0;
      irq_level      <= 1'b0;
    end else if (step) begin
      column_count   <= column_count_next;
      line_count     <= line_count_next;
      display_enable <= display_enable_next;
      enable_latch   <= enable_latch_next;
      ef1_level      <= ef1_level_next;
      irq_level      <= irq_level_next;
    end
  end

  `VDTG_ASSERT_ALWAYS(a_col_range, clk, rst, column_count <= vdtg_pkg::COL_LAST)
  `VDTG_ASSERT_ALWAYS(a_line_range, clk, rst, line_count <= vdtg_pkg::LINE_LAST)
  `VDTG_ASSERT_ALWAYS(a_irq_in_ef1, clk, rst, !irq_level || ef1_level)
  `VDTG_ASSERT_NEXT(a_wrap_load, clk, rst, step && wrap,
    line_count == '0 && column_count == '0 && display_enable == $past(enable_latch))

endmodule

[rtl/video_dma_timing_generator_top.sv]
// Video timing generator with DMA: usage notes
//   Input channel s_*: one transfer per processor machine cycle. s_tuser carries
//   the access kind (tick, input access sets the enable latch, output access
//   clears it); s_tdata carries the processor state and the data bus byte.
//   Output channel m_*: exactly one result transfer per input transfer, in order.
//   m_tuser flags every tick result; pixels are zero unless in the field in DMA state.
//   Each accepted input passes through the input register, then through the counter
//   logic into the result register, before its result appears on m_*.
//   Throughput: one transfer per cycle while the receiver holds m_tready high.
//   Reset (rst, synchronous) clears counters, flags, enable and latch, and
//   empties both registers; the first result after reset starts from line 0.
//   When the receiver holds m_tready low the result register and then the input
//   register fill; s_tready drops only when both hold an item, and nothing is
//   lost or repeated. Display enable changes take effect at the frame wrap.
`timescale 1ns / 1ps

module video_dma_timing_generator_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // cpu_state[1:0], data_bus[9:2], zero fill
  input  logic [1:0]  s_tuser,   // func[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // flag_ef1[0], irq_out[1], dma_request[2],
                                 // pixels[10:3], column[14:11], line[23:15],
                                 // frame_start[24], zero fill
  output logic [0:0]  m_tuser    // pixel_valid[0]
);

  logic              in_valid;
  vdtg_pkg::item_t   in_item;
  logic              adv;
  vdtg_pkg::result_t result;
  vdtg_pkg::result_t out_result;

  assign adv      = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.func      <= s_tuser;
      in_item.cpu_state <= s_tdata[1:0];
      in_item.data_bus  <= s_tdata[9:2];
    end
  end

  vdtg_timing u_timing (
    .clk    (clk),
    .rst    (rst),
    .step   (adv),
    .item   (in_item),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_result <= result;
    end
  end

  assign m_tdata = {7'd0,
                    out_result.frame_start,
                    out_result.line,
                    out_result.column,
                    out_result.pixels,
                    out_result.dma_request,
                    out_result.irq_out,
                    out_result.flag_ef1};
  assign m_tuser = out_result.pixel_valid;

endmodule

[verif/tb.sv]
// testbench for the video dma timing generator: directed, latch runs across lines, random traffic and a drain
`timescale 1ns / 1ps

module tb;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned RANDOM_ITEMS = 340;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [0:0]  m_tuser;

  // predictor state
  logic [vdtg_pkg::ColWidth-1:0]  col_now = '0;
  logic [vdtg_pkg::LineWidth-1:0] line_now = '0;
  logic                           disp_en = 1'b0;
  logic                           en_latch = 1'b0;
  logic                           ef1_lvl = 1'b0;
  logic                           irq_lvl = 1'b0;

  vdtg_pkg::result_t video_result_q[$];
  vdtg_pkg::result_t want_r;
  bit          gaps_on = 1'b1;
  int unsigned ready_wait = 0;
  int unsigned stall_draw;
  int unsigned idle_cycles = 0;
  int unsigned error_count = 0;
  int unsigned items_sent = 0;
  int unsigned results_checked = 0;
  int unsigned frame_wraps = 0;

  always #2 clk = ~clk;

  video_dma_timing_generator_top DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  function automatic vdtg_pkg::result_t predict_video_cycle(logic [1:0] func, logic [1:0] cs,
                                                            logic [7:0] data);
    vdtg_pkg::result_t r;
    logic              field;
    r = '0;
    case (func)
      vdtg_pkg::FUNC_TICK: begin
        if (col_now == vdtg_pkg::COL_LAST) begin
          col_now = '0;
          line_now = line_now + 1'b1;
          if (line_now == vdtg_pkg::LINE_EF1_ON_A) begin
            ef1_lvl = 1'b1;
          end else if (line_now == vdtg_pkg::LINE_IRQ_ON) begin
            irq_lvl = 1'b1;
          end else if (line_now == vdtg_pkg::LINE_FIELD_ON) begin
            irq_lvl = 1'b0;
            ef1_lvl = 1'b0;
          end else if (line_now == vdtg_pkg::LINE_EF1_ON_B) begin
            ef1_lvl = 1'b1;
          end else if (line_now == vdtg_pkg::LINE_FIELD_END) begin
            ef1_lvl = 1'b0;
          end else if (line_now > vdtg_pkg::LINE_LAST) begin
            line_now = '0;
            disp_en = en_latch;
            r.frame_start = 1'b1;
            frame_wraps++;
          end
        end else begin
          col_now = col_now + 1'b1;
        end
        r.pixel_valid = 1'b1;
      end
      vdtg_pkg::FUNC_INPUT:  en_latch = 1'b1;
      vdtg_pkg::FUNC_OUTPUT: en_latch = 1'b0;
      default: ;
    endcase
    field = (line_now >= vdtg_pkg::LINE_FIELD_ON) && (line_now < vdtg_pkg::LINE_FIELD_END);
    if (func == vdtg_pkg::FUNC_TICK && field && cs == vdtg_pkg::CPU_STATE_DMA) begin
      r.pixels = data;
    end
    r.dma_request = disp_en && field && (col_now >= vdtg_pkg::DMA_COL_FIRST) &&
                    (col_now <= vdtg_pkg::DMA_COL_LAST);
    r.flag_ef1 = ef1_lvl;
    r.irq_out = irq_lvl;
    r.column = col_now;
    r.line = line_now;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at result %0d: %s", results_checked, msg);
    error_count++;
  endtask

  task automatic report_field(string name, int unsigned got, int unsigned want);
    if (got != want) begin
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    end
  endtask

  task automatic send_item(logic [1:0] func, logic [1:0] cs, logic [7:0] data);
    int unsigned gap;
    gap = gaps_on ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= {6'b0, data, cs};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    video_result_q.push_back(predict_video_cycle(func, cs, data));
    items_sent++;
  endtask

  task automatic wait_results_drained();
    s_tvalid <= 1'b0;
    while (video_result_q.size() != 0) @(posedge clk);
  endtask

  // mostly dma-state ticks with random bytes, now and then an access or an unused code
  task automatic run_ticks(logic [vdtg_pkg::LineWidth-1:0] stop_line, int unsigned wraps,
                           logic [1:0] access_func);
    int unsigned wrap_goal;
    logic [1:0]  cs;
    wrap_goal = frame_wraps + wraps;
    do begin
      cs = ($urandom_range(0, 3) != 0) ? vdtg_pkg::CPU_STATE_DMA : 2'($urandom_range(0, 3));
      case ($urandom_range(0, 59))
        0:       send_item(access_func, cs, 8'($urandom));
        1:       send_item(FUNC_UNUSED, cs, 8'($urandom));
        default: send_item(vdtg_pkg::FUNC_TICK, cs, 8'($urandom));
      endcase
    end while (frame_wraps < wrap_goal || line_now != stop_line);
  endtask

  task automatic test_directed_corners();
    send_item(vdtg_pkg::FUNC_TICK, vdtg_pkg::CPU_STATE_DMA, 8'hff);
    send_item(FUNC_UNUSED, 2'd3, 8'hff);
    send_item(vdtg_pkg::FUNC_INPUT, 2'd0, 8'h00);
    send_item(vdtg_pkg::FUNC_OUTPUT, 2'd1, 8'haa);
    send_item(vdtg_pkg::FUNC_TICK, 2'd0, 8'h55);
    send_item(vdtg_pkg::FUNC_TICK, 2'd3, 8'h00);
    send_item(vdtg_pkg::FUNC_TICK, 2'd1, 8'h80);
    send_item(vdtg_pkg::FUNC_TICK, vdtg_pkg::CPU_STATE_DMA, 8'h01);
    send_item(vdtg_pkg::FUNC_INPUT, 2'd3, 8'h7f);
    send_item(vdtg_pkg::FUNC_INPUT, vdtg_pkg::CPU_STATE_DMA, 8'hfe);
    send_item(vdtg_pkg::FUNC_OUTPUT, 2'd0, 8'h00);
    send_item(vdtg_pkg::FUNC_OUTPUT, 2'd3, 8'hff);
    send_item(FUNC_UNUSED, 2'd0, 8'h00);
  endtask

  // latch set and cleared between runs of ticks across line boundaries
  task automatic test_enable_latch();
    send_item(vdtg_pkg::FUNC_INPUT, 2'($urandom_range(0, 3)), 8'($urandom));
    gaps_on = 1'b0;
    run_ticks(9'd1, 0, vdtg_pkg::FUNC_INPUT);
    send_item(vdtg_pkg::FUNC_OUTPUT, vdtg_pkg::CPU_STATE_DMA, 8'($urandom));
    gaps_on = 1'b1;
    run_ticks(9'd2, 0, vdtg_pkg::FUNC_OUTPUT);
  endtask

  task automatic test_random_traffic();
    logic [1:0] func;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      gaps_on = !(i >= 150 && i < 250);
      case ($urandom_range(0, 19))
        0, 1, 2:   func = vdtg_pkg::FUNC_INPUT;
        3, 4, 5:   func = vdtg_pkg::FUNC_OUTPUT;
        6, 7:      func = FUNC_UNUSED;
        default:   func = vdtg_pkg::FUNC_TICK;
      endcase
      send_item(func, 2'($urandom_range(0, 3)), 8'($urandom));
    end
    gaps_on = 1'b1;
  endtask

  task automatic test_pause_until_drained();
    for (int i = 0; i < 20; i++) begin
      send_item(vdtg_pkg::FUNC_TICK, vdtg_pkg::CPU_STATE_DMA, 8'($urandom));
    end
    wait_results_drained();
    for (int i = 0; i < 5; i++) begin
      send_item(vdtg_pkg::FUNC_TICK, 2'($urandom_range(0, 3)), 8'($urandom));
    end
  endtask

  // receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      ready_wait <= 0;
    end else if (m_tvalid && m_tready) begin
      stall_draw = gaps_on ? $urandom_range(0, 9) : 0;
      ready_wait <= stall_draw;
      m_tready <= (stall_draw == 0);
    end else if (ready_wait > 0) begin
      ready_wait <= ready_wait - 1;
      m_tready <= (ready_wait == 1);
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (video_result_q.size() == 0) begin
        report_mismatch("result transfer with nothing expected");
      end else begin
        want_r = video_result_q.pop_front();
        report_field("flag_ef1", 32'(m_tdata[0]), 32'(want_r.flag_ef1));
        report_field("irq_out", 32'(m_tdata[1]), 32'(want_r.irq_out));
        report_field("dma_request", 32'(m_tdata[2]), 32'(want_r.dma_request));
        report_field("pixels", 32'(m_tdata[10:3]), 32'(want_r.pixels));
        report_field("column", 32'(m_tdata[14:11]), 32'(want_r.column));
        report_field("line", 32'(m_tdata[23:15]), 32'(want_r.line));
        report_field("frame_start", 32'(m_tdata[24]), 32'(want_r.frame_start));
        report_field("pixel_valid", 32'(m_tuser[0]), 32'(want_r.pixel_valid));
      end
      results_checked++;
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("video_dma_timing_generator_top verification failed");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed_corners();
    test_enable_latch();
    test_random_traffic();
    test_pause_until_drained();
    wait_results_drained();
    repeat (8) @(posedge clk);
    if (video_result_q.size() != 0) begin
      report_mismatch("expected results left over");
    end
    $display("sent %0d items, checked %0d results across %0d frame wraps",
             items_sent, results_checked, frame_wraps);
    $display("covered access corners, latch accesses between ticks, random traffic and a drain");
    if (error_count == 0) begin
      $display("video_dma_timing_generator_top verification clean");
    end else begin
      $display("video_dma_timing_generator_top verification failed");
    end
    $finish;
  end

endmodule
